/* hdl/rglim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rglim_pkg
// Shared types and constants for the ramped gain soft limiter.
// ----------------------------------------------------------------------------
package rglim_pkg;

   localparam int SAMPLE_W = 24;
   localparam int OUT_W    = 22;
   localparam int GAIN_W   = 18;
   localparam int LEN_W    = 13;
   localparam int CC_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASSTHROUGH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVELING_ENABLE = 2'd2;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 18'd65536;
   localparam logic [25:0] ONE_Q20    = 26'd1048576;
   localparam logic [25:0] KNEE_START = 26'd996147;
   localparam logic [15:0] KNEE_SPAN  = 16'd52429;
   localparam logic [29:0] X_LIMIT    = 30'd2621440;
   localparam logic [25:0] PADE_15    = 26'd15728640;

   // shared divider sizing
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 26;
   localparam int DIV_Q_W   = 24;
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic                passthrough;
      logic                leveling;
      logic                negative;
      logic [SAMPLE_W-1:0] magnitude;
      logic [GAIN_W-1:0]   start_gain;
      logic [GAIN_W-1:0]   target_gain;
      logic [LEN_W-1:0]    ramp_length;
      logic [LEN_W-1:0]    frame_position;
      logic                block_last;
   } work_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numerator;
      logic [DIV_DEN_W-1:0] denominator;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* hdl/rglim_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rglim_front
// Takes transactions, tracks block and frame position, latches block gains.
// ----------------------------------------------------------------------------
module rglim_front #(
   parameter int MAX_BLOCK_FRAMES = 4096,
   parameter int MAX_CHANNELS     = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic signed [rglim_pkg::SAMPLE_W-1:0] sample_in,
   input  logic [rglim_pkg::GAIN_W-1:0]          target_gain,
   input  logic [rglim_pkg::LEN_W-1:0]           block_frames,
   input  logic                                 csr_write_enable,
   input  logic [rglim_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rglim_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output rglim_pkg::work_type                   work
);

   localparam int CPOS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [rglim_pkg::CC_W-1:0] MAX_CC =
      (MAX_CHANNELS > 15) ? 4'd15 : rglim_pkg::CC_W'(MAX_CHANNELS);
   localparam logic [rglim_pkg::LEN_W-1:0] MAX_LEN =
      (MAX_BLOCK_FRAMES > 8191) ? 13'd8191 : rglim_pkg::LEN_W'(MAX_BLOCK_FRAMES);

   logic [rglim_pkg::CC_W-1:0]   channel_count_ff;
   logic                         passthrough_ff;
   logic                         leveling_ff;
   logic [rglim_pkg::GAIN_W-1:0] previous_gain_ff, previous_gain_in;
   logic [rglim_pkg::GAIN_W-1:0] start_gain_ff, start_gain_in;
   logic [rglim_pkg::GAIN_W-1:0] target_gain_ff, target_gain_in;
   logic [rglim_pkg::LEN_W-1:0]  length_ff, length_in;
   logic [rglim_pkg::LEN_W-1:0]  frame_ff, frame_in;
   logic [CPOS_W-1:0]            chan_ff, chan_in;

   logic [rglim_pkg::CC_W-1:0]     chans;
   logic [rglim_pkg::LEN_W-1:0]    len_new;
   logic                           block_start;
   logic                           frame_end;
   logic                           last;
   logic [rglim_pkg::SAMPLE_W-1:0] raw;

   always_comb begin
      raw = sample_in;
      if (channel_count_ff == '0) begin
         chans = 4'd1;
      end else if (channel_count_ff > MAX_CC) begin
         chans = MAX_CC;
      end else begin
         chans = channel_count_ff;
      end
      if (block_frames == '0) begin
         len_new = 13'd1;
      end else if (block_frames > MAX_LEN) begin
         len_new = MAX_LEN;
      end else begin
         len_new = block_frames;
      end
      block_start = (frame_ff == '0) && (chan_ff == '0);
      previous_gain_in = previous_gain_ff;
      start_gain_in    = start_gain_ff;
      target_gain_in   = target_gain_ff;
      length_in        = length_ff;
      if (block_start) begin
         start_gain_in  = previous_gain_ff;
         target_gain_in = target_gain;
         length_in      = len_new;
         if (leveling_ff) begin
            previous_gain_in = target_gain;
         end
      end
      frame_end = (5'(chan_ff) + 5'd1) >= 5'(chans);
      last      = 1'b0;
      chan_in   = chan_ff + 1'b1;
      frame_in  = frame_ff;
      if (frame_end) begin
         chan_in = '0;
         if ((14'(frame_ff) + 14'd1) >= 14'(length_in)) begin
            frame_in = '0;
            last     = 1'b1;
         end else begin
            frame_in = frame_ff + 1'b1;
         end
      end

      work.passthrough    = passthrough_ff;
      work.leveling       = leveling_ff;
      work.negative       = raw[rglim_pkg::SAMPLE_W-1];
      work.magnitude      = raw[rglim_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
      work.start_gain     = start_gain_in;
      work.target_gain    = target_gain_in;
      work.ramp_length    = length_in;
      work.frame_position = frame_ff;
      work.block_last     = last & ~passthrough_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= 4'd2;
         passthrough_ff   <= 1'b0;
         leveling_ff      <= 1'b1;
         previous_gain_ff <= rglim_pkg::UNITY_GAIN;
         start_gain_ff    <= rglim_pkg::UNITY_GAIN;
         target_gain_ff   <= rglim_pkg::UNITY_GAIN;
         length_ff        <= '0;
         frame_ff         <= '0;
         chan_ff          <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rglim_pkg::CSR_CHANNEL_COUNT:   channel_count_ff <= csr_write_data;
               rglim_pkg::CSR_PASSTHROUGH:     passthrough_ff   <= csr_write_data[0];
               rglim_pkg::CSR_LEVELING_ENABLE: leveling_ff      <= csr_write_data[0];
               default: ;
            endcase
         end
         if (accept && !passthrough_ff) begin
            previous_gain_ff <= previous_gain_in;
            start_gain_ff    <= start_gain_in;
            target_gain_ff   <= target_gain_in;
            length_ff        <= length_in;
            frame_ff         <= frame_in;
            chan_ff          <= chan_in;
         end
      end
   end

endmodule

/* hdl/rglim_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rglim_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module rglim_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rglim_pkg::work_type push_data,
   input  logic                pop,
   output rglim_pkg::work_type pop_data,
   output logic                full,
   output logic                empty
);

   rglim_pkg::work_type entry_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] count_ff;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

/* hdl/rglim_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rglim_div
// Restoring divider, one quotient bit per cycle, shared by ramp and limiter.
// ----------------------------------------------------------------------------
module rglim_div (
   input  logic                   clock,
   input  logic                   reset,
   input  rglim_pkg::div_req_type req,
   output rglim_pkg::div_rsp_type rsp
);

   localparam int DSR_W = rglim_pkg::DIV_DEN_W + rglim_pkg::DIV_Q_W;

   logic [DSR_W-1:0]                 rem_ff;
   logic [DSR_W-1:0]                 dsr_ff;
   logic [rglim_pkg::DIV_Q_W-1:0]    quo_ff;
   logic [rglim_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic                             busy_ff;
   logic                             done_ff;
   logic                             fits;

   assign fits         = rem_ff >= dsr_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= DSR_W'(req.numerator);
         dsr_ff <= DSR_W'(req.denominator) << (rglim_pkg::DIV_Q_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsr_ff;
         end
         dsr_ff <= dsr_ff >> 1;
         quo_ff <= {quo_ff[rglim_pkg::DIV_Q_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= rglim_pkg::DIV_CNT_W'(rglim_pkg::DIV_Q_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

/* hdl/rglim_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rglim_back
// Ramp gain, gain multiply, soft limiter and result register.
// ----------------------------------------------------------------------------
module rglim_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                queue_empty,
   input  rglim_pkg::work_type                 work,
   output logic                                pop,
   output rglim_pkg::div_req_type              div_req,
   input  rglim_pkg::div_rsp_type              div_rsp,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rglim_pkg::OUT_W-1:0]  rsp_sample_out,
   output logic                                rsp_limited,
   output logic                                rsp_block_last
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_GAIN  = 10'b0000000010,
      S_RDIV  = 10'b0000000100,
      S_MUL   = 10'b0000001000,
      S_SCALE = 10'b0000010000,
      S_SQ    = 10'b0000100000,
      S_NUM   = 10'b0001000000,
      S_PDIV  = 10'b0010000000,
      S_KNEE  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type                    state_ff, state_in;
   rglim_pkg::work_type          item_ff;
   logic [rglim_pkg::GAIN_W-1:0] gain_ff;
   logic [41:0]                  prod_ff;
   logic [29:0]                  x_ff;
   logic [22:0]                  x2_ff;
   logic [20:0]                  tanh_ff;
   logic [25:0]                  res_ff, res_in;
   logic                         lim_ff, lim_in;

   logic [rglim_pkg::GAIN_W-1:0] diff;
   logic [12:0]                  span;
   logic [30:0]                  ramp_prod;
   logic [25:0]                  scaled;
   logic [29:0]                  x_in;
   logic [43:0]                  sq;
   logic [25:0]                  pade_den;
   logic [46:0]                  pade_num;
   logic [36:0]                  knee;

   always_comb begin
      diff = (item_ff.target_gain >= item_ff.start_gain) ?
             (item_ff.target_gain - item_ff.start_gain) :
             (item_ff.start_gain - item_ff.target_gain);
      span      = item_ff.ramp_length - 1'b1;
      ramp_prod = diff * item_ff.frame_position;
      scaled    = 26'((prod_ff + 42'd32768) >> 16);
      x_in      = (30'(scaled) - 30'(rglim_pkg::KNEE_START)) * 30'd20;
      sq        = x_ff[21:0] * x_ff[21:0];
      pade_den  = rglim_pkg::PADE_15 + 26'(x2_ff) * 26'd6;
      pade_num  = x_ff[21:0] * (25'(rglim_pkg::PADE_15) + 25'(x2_ff));
      knee      = rglim_pkg::KNEE_SPAN * tanh_ff + 37'd524288;

      state_in         = state_ff;
      pop              = 1'b0;
      div_req.start    = 1'b0;
      div_req.numerator   = '0;
      div_req.denominator = '0;
      res_in = res_ff;
      lim_in = lim_ff;
      case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            if (item_ff.passthrough) begin
               lim_in   = 26'(item_ff.magnitude) > rglim_pkg::ONE_Q20;
               res_in   = lim_in ? rglim_pkg::ONE_Q20 : 26'(item_ff.magnitude);
               state_in = S_OUT;
            end else if (item_ff.leveling && item_ff.ramp_length > 13'd1) begin
               div_req.start       = 1'b1;
               div_req.numerator   = 48'({ramp_prod, 1'b0}) + 48'(span);
               div_req.denominator = 26'({span, 1'b0});
               state_in            = S_RDIV;
            end else begin
               state_in = S_MUL;
            end
         end
         S_RDIV: begin
            if (div_rsp.done) begin
               state_in = S_MUL;
            end
         end
         S_MUL:   state_in = S_SCALE;
         S_SCALE: begin
            if (scaled > rglim_pkg::KNEE_START) begin
               lim_in   = 1'b1;
               state_in = (x_in > rglim_pkg::X_LIMIT) ? S_KNEE : S_SQ;
            end else begin
               lim_in   = 1'b0;
               res_in   = scaled;
               state_in = S_OUT;
            end
         end
         S_SQ:  state_in = S_NUM;
         S_NUM: begin
            div_req.start       = 1'b1;
            div_req.numerator   = 48'(pade_num) + 48'(pade_den >> 1);
            div_req.denominator = pade_den;
            state_in            = S_PDIV;
         end
         S_PDIV: begin
            if (div_rsp.done) begin
               state_in = S_KNEE;
            end
         end
         S_KNEE: begin
            res_in   = rglim_pkg::KNEE_START + 26'(knee >> 20);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      lim_ff <= lim_in;
      if (pop) begin
         item_ff <= work;
      end
      if (state_ff == S_GAIN) begin
         if (!item_ff.leveling) begin
            gain_ff <= rglim_pkg::UNITY_GAIN;
         end else begin
            gain_ff <= item_ff.target_gain;
         end
      end
      if (state_ff == S_RDIV && div_rsp.done) begin
         if (item_ff.target_gain >= item_ff.start_gain) begin
            gain_ff <= item_ff.start_gain + div_rsp.quotient[rglim_pkg::GAIN_W-1:0];
         end else begin
            gain_ff <= item_ff.start_gain - div_rsp.quotient[rglim_pkg::GAIN_W-1:0];
         end
      end
      if (state_ff == S_MUL) begin
         prod_ff <= item_ff.magnitude * gain_ff;
      end
      if (state_ff == S_SCALE) begin
         x_ff    <= x_in;
         tanh_ff <= 21'(rglim_pkg::ONE_Q20);
      end
      if (state_ff == S_SQ) begin
         x2_ff <= 23'((sq + 44'd524288) >> 20);
      end
      if (state_ff == S_PDIV && div_rsp.done) begin
         tanh_ff <= (div_rsp.quotient > 24'(rglim_pkg::ONE_Q20)) ?
                    21'(rglim_pkg::ONE_Q20) : div_rsp.quotient[20:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid      = state_ff == S_OUT;
   assign rsp_sample_out = item_ff.negative ? -$signed(res_ff[rglim_pkg::OUT_W-1:0])
                                            : $signed(res_ff[rglim_pkg::OUT_W-1:0]);
   assign rsp_limited    = lim_ff;
   assign rsp_block_last = item_ff.block_last;

endmodule

/* hdl/ramped_gain_soft_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_gain_soft_limiter
// Ramped block gain and Pade tanh soft limiter on interleaved samples.
// The back end takes one transaction at a time, and each ramp or limiter
// division holds it in the shared 24-step divider; the queue ahead of it
// still accepts new transactions until it is full.
// Reset: synchronous, returns gains to unity, positions to zero, csr defaults.
// ----------------------------------------------------------------------------
module ramped_gain_soft_limiter #(
   parameter int MAX_BLOCK_FRAMES = 4096,
   parameter int MAX_CHANNELS     = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [rglim_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [rglim_pkg::GAIN_W-1:0]          req_target_gain,
   input  logic [rglim_pkg::LEN_W-1:0]           req_block_frames,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rglim_pkg::OUT_W-1:0]    rsp_sample_out,
   output logic                                 rsp_limited,
   output logic                                 rsp_block_last,
   input  logic                                 csr_write_enable,
   input  logic [rglim_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rglim_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   rglim_pkg::work_type    front_work;
   rglim_pkg::work_type    queue_work;
   rglim_pkg::div_req_type div_req;
   rglim_pkg::div_rsp_type div_rsp;
   logic accept, full, empty, pop;

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   rglim_front #(
      .MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES),
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .sample_in(req_sample_in),
      .target_gain(req_target_gain),
      .block_frames(req_block_frames),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .work(front_work)
   );

   rglim_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(accept),
      .push_data(front_work),
      .pop(pop),
      .pop_data(queue_work),
      .full(full),
      .empty(empty)
   );

   rglim_div u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .rsp(div_rsp)
   );

   rglim_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(empty),
      .work(queue_work),
      .pop(pop),
      .div_req(div_req),
      .div_rsp(div_rsp),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .rsp_limited(rsp_limited),
      .rsp_block_last(rsp_block_last)
   );

endmodule
